// ----- rtl/bir_pkg.sv -----
// Shared types, widths and constants for the bilinear image resize core.
// No dependencies; every other file of the block but bir_ram imports this package.
package bir_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned PIX_W     = CHAN_W * NUM_CHAN;
  localparam int unsigned SIZE_W    = 10;
  localparam int unsigned RATIO_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DEF_MAX_SRC_WIDTH  = 512;
  localparam int unsigned DEF_MAX_SRC_HEIGHT = 512;
  localparam int unsigned DEF_FRAC_BITS      = 16;

  localparam logic [SIZE_W-1:0]  RST_SRC_WIDTH  = SIZE_W'(512);
  localparam logic [SIZE_W-1:0]  RST_SRC_HEIGHT = SIZE_W'(512);
  localparam logic [RATIO_W-1:0] RST_RATIO      = RATIO_W'(65536);

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_X_RATIO    = 2'd2,
    REG_Y_RATIO    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               is_load;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } tag_t;

  // Last valid index of an axis: a size of zero acts as one, and a size above
  // the store limit acts as the limit.
  function automatic logic [COORD_W-1:0] size_last(input logic [SIZE_W-1:0] size,
                                                   input logic [COORD_W:0] limit);
    logic [COORD_W:0] eff;
    if (size == '0) begin
      eff = (COORD_W+1)'(1);
    end else if ((COORD_W+1)'(size) > limit) begin
      eff = limit;
    end else begin
      eff = (COORD_W+1)'(size);
    end
    size_last = COORD_W'(eff - (COORD_W+1)'(1));
  endfunction

endpackage

// ----- rtl/bir_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bir_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bir_addr_map.sv -----
// Position mapping stages: ratio multiply, then index clamp and fraction split (loads pass their coordinates).
// Depends on bir_pkg.
module bir_addr_map #(
  parameter int unsigned MAX_SRC_WIDTH  = bir_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = bir_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned FRAC_BITS      = bir_pkg::DEF_FRAC_BITS,
  localparam int unsigned XW = $clog2(MAX_SRC_WIDTH),
  localparam int unsigned YW = $clog2(MAX_SRC_HEIGHT)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bir_pkg::SIZE_W-1:0]    src_width,
  input  logic [bir_pkg::SIZE_W-1:0]    src_height,
  input  logic [bir_pkg::RATIO_W-1:0]   x_ratio_q16,
  input  logic [bir_pkg::RATIO_W-1:0]   y_ratio_q16,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [bir_pkg::COORD_W-1:0]   row,
  input  logic [bir_pkg::COORD_W-1:0]   col,
  input  logic [bir_pkg::CHAN_W-1:0]    chan0,
  input  logic [bir_pkg::CHAN_W-1:0]    chan1,
  input  logic [bir_pkg::CHAN_W-1:0]    chan2,
  output logic                          b_valid,
  input  logic                          b_ready,
  output bir_pkg::tag_t                 b_tag,
  output logic [XW-1:0]                 x0,
  output logic [XW-1:0]                 x1,
  output logic [YW-1:0]                 y0,
  output logic [YW-1:0]                 y1,
  output logic [FRAC_BITS-1:0]          fx,
  output logic [FRAC_BITS-1:0]          fy,
  output logic [bir_pkg::PIX_W-1:0]     b_pix
);
  import bir_pkg::*;

  localparam int unsigned PRODW = COORD_W + RATIO_W;
  localparam int unsigned IPW   = PRODW - FRAC_BITS;

  logic             a_valid;
  logic             a_en;
  logic             b_en;
  tag_t             a_tag;
  logic [PRODW-1:0] prod_x;
  logic [PRODW-1:0] prod_y;
  logic [PIX_W-1:0] a_pix;
  logic [XW-1:0]    x_last;
  logic [YW-1:0]    y_last;
  logic [IPW-1:0]   ip_x;
  logic [IPW-1:0]   ip_y;
  logic [XW-1:0]    x_lo;
  logic [XW-1:0]    x_hi;
  logic [YW-1:0]    y_lo;
  logic [YW-1:0]    y_hi;
  logic             load_ok;

  assign b_en     = !b_valid || b_ready;
  assign a_en     = !a_valid || b_en;
  assign in_ready = a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_tag  <= '{is_load: (kind == KIND_LOAD), row: row, col: col};
      prod_x <= PRODW'(col) * PRODW'(x_ratio_q16);
      prod_y <= PRODW'(row) * PRODW'(y_ratio_q16);
      a_pix  <= {chan2, chan1, chan0};
    end
  end

  assign x_last = XW'(size_last(src_width, (COORD_W+1)'(MAX_SRC_WIDTH)));
  assign y_last = YW'(size_last(src_height, (COORD_W+1)'(MAX_SRC_HEIGHT)));
  assign ip_x   = prod_x[PRODW-1:FRAC_BITS];
  assign ip_y   = prod_y[PRODW-1:FRAC_BITS];

  always_comb begin
    if (ip_x > IPW'(x_last)) begin
      x_lo = x_last;
    end else begin
      x_lo = XW'(ip_x);
    end
    if (ip_y > IPW'(y_last)) begin
      y_lo = y_last;
    end else begin
      y_lo = YW'(ip_y);
    end
    x_hi = (x_lo < x_last) ? x_lo + XW'(1) : x_last;
    y_hi = (y_lo < y_last) ? y_lo + YW'(1) : y_last;
    load_ok = ((COORD_W+1)'(a_tag.row) < (COORD_W+1)'(MAX_SRC_HEIGHT)) &&
              ((COORD_W+1)'(a_tag.col) < (COORD_W+1)'(MAX_SRC_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_en) begin
      b_valid <= a_valid && (!a_tag.is_load || load_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_tag <= a_tag;
      b_pix <= a_pix;
      fx    <= prod_x[FRAC_BITS-1:0];
      fy    <= prod_y[FRAC_BITS-1:0];
      if (a_tag.is_load) begin
        x0 <= XW'(a_tag.col);
        x1 <= XW'(a_tag.col);
        y0 <= YW'(a_tag.row);
        y1 <= YW'(a_tag.row);
      end else begin
        x0 <= x_lo;
        x1 <= x_hi;
        y0 <= y_lo;
        y1 <= y_hi;
      end
    end
  end

`ifndef SYNTH
  a_x_neighbors: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_tag.is_load |-> (x0 <= x_last) && (x1 == x0 || x1 == x0 + XW'(1)))
    else $error("horizontal neighbors out of order or beyond the last column");
  a_y_neighbors: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_tag.is_load |-> (y0 <= y_last) && (y1 == y0 || y1 == y0 + YW'(1)))
    else $error("vertical neighbors out of order or beyond the last row");
`endif

endmodule

// ----- rtl/bir_fetch.sv -----
// Frame store in four banks split by row and column parity, so that the four
// neighbors of a request are read in the same cycle. Depends on bir_pkg, bir_ram.
module bir_fetch #(
  parameter int unsigned MAX_SRC_WIDTH  = bir_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = bir_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned FRAC_BITS      = bir_pkg::DEF_FRAC_BITS,
  localparam int unsigned XW = $clog2(MAX_SRC_WIDTH),
  localparam int unsigned YW = $clog2(MAX_SRC_HEIGHT)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      b_valid,
  output logic                      b_ready,
  input  bir_pkg::tag_t             b_tag,
  input  logic [XW-1:0]             x0,
  input  logic [XW-1:0]             x1,
  input  logic [YW-1:0]             y0,
  input  logic [YW-1:0]             y1,
  input  logic [FRAC_BITS-1:0]      fx,
  input  logic [FRAC_BITS-1:0]      fy,
  input  logic [bir_pkg::PIX_W-1:0] b_pix,
  output logic                      c_valid,
  input  logic                      c_ready,
  output bir_pkg::tag_t             c_tag,
  output logic [FRAC_BITS-1:0]      c_fx,
  output logic [FRAC_BITS-1:0]      c_fy,
  output logic [bir_pkg::PIX_W-1:0] nb_a,
  output logic [bir_pkg::PIX_W-1:0] nb_b,
  output logic [bir_pkg::PIX_W-1:0] nb_c,
  output logic [bir_pkg::PIX_W-1:0] nb_d
);
  import bir_pkg::*;

  localparam int unsigned NUM_BANKS  = 4;
  localparam int unsigned HALF_W     = (MAX_SRC_WIDTH + 1) / 2;
  localparam int unsigned HALF_H     = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int unsigned BANK_DEPTH = HALF_W * HALF_H;
  localparam int unsigned BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic                 c_en;
  logic [NUM_BANKS-1:0] bank_we;
  logic [BAW-1:0]       bank_addr [NUM_BANKS];
  logic [PIX_W-1:0]     bank_rd   [NUM_BANKS];
  logic [1:0]           sel_a;
  logic [1:0]           sel_b;
  logic [1:0]           sel_c;
  logic [1:0]           sel_d;

  assign c_en    = !c_valid || c_ready;
  assign b_ready = c_en;

  for (genvar bi = 0; bi < NUM_BANKS; bi++) begin : g_bank
    localparam logic ROW_PAR = 1'(bi / 2);
    localparam logic COL_PAR = 1'(bi % 2);
    logic [YW-1:0] row_sel;
    logic [XW-1:0] col_sel;

    assign row_sel = (y0[0] == ROW_PAR) ? y0 : y1;
    assign col_sel = (x0[0] == COL_PAR) ? x0 : x1;
    assign bank_addr[bi] = BAW'(row_sel >> 1) * BAW'(HALF_W) + BAW'(col_sel >> 1);
    assign bank_we[bi] = b_valid && b_tag.is_load && c_en &&
                         (y0[0] == ROW_PAR) && (x0[0] == COL_PAR);

    bir_ram #(
      .WIDTH(PIX_W),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (bank_we[bi]),
      .waddr(bank_addr[bi]),
      .wdata(b_pix),
      .re   (c_en),
      .raddr(bank_addr[bi]),
      .rdata(bank_rd[bi])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_en) begin
      c_valid <= b_valid && !b_tag.is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en) begin
      c_tag <= b_tag;
      c_fx  <= fx;
      c_fy  <= fy;
      sel_a <= {y0[0], x0[0]};
      sel_b <= {y0[0], x1[0]};
      sel_c <= {y1[0], x0[0]};
      sel_d <= {y1[0], x1[0]};
    end
  end

  assign nb_a = bank_rd[sel_a];
  assign nb_b = bank_rd[sel_b];
  assign nb_c = bank_rd[sel_c];
  assign nb_d = bank_rd[sel_d];

`ifndef SYNTH
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    (|bank_we) |-> $onehot(bank_we) && b_tag.is_load && c_en)
    else $error("frame store write outside a single advancing load");
`endif

endmodule

// ----- rtl/bir_blend.sv -----
// Weighting stages: weight products, per-neighbor products, pair sums, and the
// final sum with truncation into the output register. Depends on bir_pkg.
module bir_blend #(
  parameter int unsigned FRAC_BITS = bir_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        c_valid,
  output logic                        c_ready,
  input  bir_pkg::tag_t               c_tag,
  input  logic [FRAC_BITS-1:0]        c_fx,
  input  logic [FRAC_BITS-1:0]        c_fy,
  input  logic [bir_pkg::PIX_W-1:0]   nb_a,
  input  logic [bir_pkg::PIX_W-1:0]   nb_b,
  input  logic [bir_pkg::PIX_W-1:0]   nb_c,
  input  logic [bir_pkg::PIX_W-1:0]   nb_d,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bir_pkg::COORD_W-1:0] out_row,
  output logic [bir_pkg::COORD_W-1:0] out_col,
  output logic [bir_pkg::CHAN_W-1:0]  pix0,
  output logic [bir_pkg::CHAN_W-1:0]  pix1,
  output logic [bir_pkg::CHAN_W-1:0]  pix2
);
  import bir_pkg::*;

  localparam int unsigned NUM_NB = 4;
  localparam int unsigned WW     = 2 * FRAC_BITS + 1;
  localparam int unsigned PRW    = WW + CHAN_W;
  localparam int unsigned SW     = PRW + 2;
  localparam int unsigned SCW    = SW - 2 * FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [WW+1:0]      WSUM = (WW+2)'(1) << (2 * FRAC_BITS);

  logic               d_en;
  logic               e_en;
  logic               f_en;
  logic               out_en;
  logic [FRAC_BITS:0] inv_fx;
  logic [FRAC_BITS:0] inv_fy;
  logic [PIX_W-1:0]   nb_in [NUM_NB];

  logic               d_valid;
  tag_t               d_tag;
  logic [WW-1:0]      d_w  [NUM_NB];
  logic [PIX_W-1:0]   d_px [NUM_NB];

  logic               e_valid;
  tag_t               e_tag;
  logic [PRW-1:0]     e_prod [NUM_CHAN][NUM_NB];

  logic               f_valid;
  tag_t               f_tag;
  logic [PRW:0]       f_sum [NUM_CHAN][2];

  logic [SW-1:0]      tot       [NUM_CHAN];
  logic [SCW-1:0]     scaled    [NUM_CHAN];
  logic [CHAN_W-1:0]  pix_next  [NUM_CHAN];
  logic [CHAN_W-1:0]  out_pix   [NUM_CHAN];

  assign out_en  = !out_valid || !out_stall;
  assign f_en    = !f_valid || out_en;
  assign e_en    = !e_valid || f_en;
  assign d_en    = !d_valid || e_en;
  assign c_ready = d_en;

  assign inv_fx   = ONE - {1'b0, c_fx};
  assign inv_fy   = ONE - {1'b0, c_fy};
  assign nb_in[0] = nb_a;
  assign nb_in[1] = nb_b;
  assign nb_in[2] = nb_c;
  assign nb_in[3] = nb_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (d_en) begin
        d_valid <= c_valid;
      end
      if (e_en) begin
        e_valid <= d_valid;
      end
      if (f_en) begin
        f_valid <= e_valid;
      end
      if (out_en) begin
        out_valid <= f_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_en) begin
      d_tag  <= c_tag;
      d_w[0] <= WW'(inv_fx) * WW'(inv_fy);
      d_w[1] <= WW'(c_fx) * WW'(inv_fy);
      d_w[2] <= WW'(inv_fx) * WW'(c_fy);
      d_w[3] <= WW'(c_fx) * WW'(c_fy);
      for (int n = 0; n < NUM_NB; n++) begin
        d_px[n] <= nb_in[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_en) begin
      e_tag <= d_tag;
      for (int k = 0; k < NUM_CHAN; k++) begin
        for (int n = 0; n < NUM_NB; n++) begin
          e_prod[k][n] <= PRW'(d_px[n][CHAN_W*k +: CHAN_W]) * PRW'(d_w[n]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      f_tag <= e_tag;
      for (int k = 0; k < NUM_CHAN; k++) begin
        f_sum[k][0] <= (PRW+1)'(e_prod[k][0]) + (PRW+1)'(e_prod[k][1]);
        f_sum[k][1] <= (PRW+1)'(e_prod[k][2]) + (PRW+1)'(e_prod[k][3]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      tot[k]    = SW'(f_sum[k][0]) + SW'(f_sum[k][1]);
      scaled[k] = tot[k][SW-1:2*FRAC_BITS];
      if (|scaled[k][SCW-1:CHAN_W]) begin
        pix_next[k] = '1;
      end else begin
        pix_next[k] = scaled[k][CHAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_row <= f_tag.row;
      out_col <= f_tag.col;
      for (int k = 0; k < NUM_CHAN; k++) begin
        out_pix[k] <= pix_next[k];
      end
    end
  end

  assign pix0 = out_pix[0];
  assign pix1 = out_pix[1];
  assign pix2 = out_pix[2];

`ifndef SYNTH
  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> ((WW+2)'(d_w[0]) + (WW+2)'(d_w[1]) + (WW+2)'(d_w[2]) +
                 (WW+2)'(d_w[3]) == WSUM))
    else $error("bilinear weights do not sum to one");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_en |=> f_valid && $stable(f_tag))
    else $error("pair sum stage lost its request under stall");
`endif

endmodule

// ----- rtl/bilinear_image_resize_core.sv -----
// Top level of the bilinear image resize core: configuration registers and
// the mapping, fetch and blend pipeline. Depends on bir_pkg and all bir_ modules.
//
//   Channel   Direction  Handshake               Payload
//   cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//   in        in         in_valid / in_stall     kind, row, col, chan0..chan2
//   out       out        out_valid / out_stall   out_row, out_col, pix0..pix2
//
// One request per clock unless in_stall holds it; each request moves through the map, fetch and blend stages.
// The rate is set by the four parity banks of the frame store, one read each per clock.
// Reset clears the valid bits and presets the config registers; the frame store is undefined until loaded.
// A stalled stage holds while the stages behind it keep filling empty slots.
// Loads write the store in the fetch stage and produce no result.
module bilinear_image_resize_core #(
  parameter int unsigned MAX_SRC_WIDTH  = bir_pkg::DEF_MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = bir_pkg::DEF_MAX_SRC_HEIGHT,
  parameter int unsigned FRAC_BITS      = bir_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bir_pkg::RATIO_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [bir_pkg::COORD_W-1:0]   row,
  input  logic [bir_pkg::COORD_W-1:0]   col,
  input  logic [bir_pkg::CHAN_W-1:0]    chan0,
  input  logic [bir_pkg::CHAN_W-1:0]    chan1,
  input  logic [bir_pkg::CHAN_W-1:0]    chan2,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bir_pkg::COORD_W-1:0]   out_row,
  output logic [bir_pkg::COORD_W-1:0]   out_col,
  output logic [bir_pkg::CHAN_W-1:0]    pix0,
  output logic [bir_pkg::CHAN_W-1:0]    pix1,
  output logic [bir_pkg::CHAN_W-1:0]    pix2
);
  import bir_pkg::*;

  localparam int unsigned XW = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned YW = $clog2(MAX_SRC_HEIGHT);

  logic [SIZE_W-1:0]    src_width;
  logic [SIZE_W-1:0]    src_height;
  logic [RATIO_W-1:0]   x_ratio_q16;
  logic [RATIO_W-1:0]   y_ratio_q16;

  logic                 in_ready;
  logic                 b_valid;
  logic                 b_ready;
  tag_t                 b_tag;
  logic [XW-1:0]        x0;
  logic [XW-1:0]        x1;
  logic [YW-1:0]        y0;
  logic [YW-1:0]        y1;
  logic [FRAC_BITS-1:0] fx;
  logic [FRAC_BITS-1:0] fy;
  logic [PIX_W-1:0]     b_pix;

  logic                 c_valid;
  logic                 c_ready;
  tag_t                 c_tag;
  logic [FRAC_BITS-1:0] c_fx;
  logic [FRAC_BITS-1:0] c_fy;
  logic [PIX_W-1:0]     nb_a;
  logic [PIX_W-1:0]     nb_b;
  logic [PIX_W-1:0]     nb_c;
  logic [PIX_W-1:0]     nb_d;

  assign cfg_ready = 1'b1;
  assign in_stall  = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= RST_SRC_WIDTH;
      src_height  <= RST_SRC_HEIGHT;
      x_ratio_q16 <= RST_RATIO;
      y_ratio_q16 <= RST_RATIO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width   <= cfg_data[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height  <= cfg_data[SIZE_W-1:0];
        REG_X_RATIO:    x_ratio_q16 <= cfg_data;
        REG_Y_RATIO:    y_ratio_q16 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bir_addr_map #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_addr_map (
    .clk        (clk),
    .rst        (rst),
    .src_width  (src_width),
    .src_height (src_height),
    .x_ratio_q16(x_ratio_q16),
    .y_ratio_q16(y_ratio_q16),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .row        (row),
    .col        (col),
    .chan0      (chan0),
    .chan1      (chan1),
    .chan2      (chan2),
    .b_valid    (b_valid),
    .b_ready    (b_ready),
    .b_tag      (b_tag),
    .x0         (x0),
    .x1         (x1),
    .y0         (y0),
    .y1         (y1),
    .fx         (fx),
    .fy         (fy),
    .b_pix      (b_pix)
  );

  bir_fetch #(
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_fetch (
    .clk    (clk),
    .rst    (rst),
    .b_valid(b_valid),
    .b_ready(b_ready),
    .b_tag  (b_tag),
    .x0     (x0),
    .x1     (x1),
    .y0     (y0),
    .y1     (y1),
    .fx     (fx),
    .fy     (fy),
    .b_pix  (b_pix),
    .c_valid(c_valid),
    .c_ready(c_ready),
    .c_tag  (c_tag),
    .c_fx   (c_fx),
    .c_fy   (c_fy),
    .nb_a   (nb_a),
    .nb_b   (nb_b),
    .nb_c   (nb_c),
    .nb_d   (nb_d)
  );

  bir_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk      (clk),
    .rst      (rst),
    .c_valid  (c_valid),
    .c_ready  (c_ready),
    .c_tag    (c_tag),
    .c_fx     (c_fx),
    .c_fy     (c_fy),
    .nb_a     (nb_a),
    .nb_b     (nb_b),
    .nb_c     (nb_c),
    .nb_d     (nb_d),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row  (out_row),
    .out_col  (out_col),
    .pix0     (pix0),
    .pix1     (pix1),
    .pix2     (pix2)
  );

endmodule

// ----- sim/bilinear_image_resize_core_tb.sv -----
// Self-checking testbench for bilinear_image_resize_core: directed table, then random phases.
// Keeps its own frame store copy and bilinear predictor and compares each result in order.
// Depends on bir_pkg and the core RTL only.
`timescale 1ns / 1ps

module bilinear_image_resize_core_tb;
  import bir_pkg::*;

  localparam int unsigned MAX_W = DEF_MAX_SRC_WIDTH;
  localparam int unsigned MAX_H = DEF_MAX_SRC_HEIGHT;
  localparam int unsigned FRAC = DEF_FRAC_BITS;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD = 80;
  localparam int PHASE_ITEMS = 48;
  localparam int NUM_PHASES = 8;
  localparam int NUM_DIRECTED = 25;

  typedef enum logic [1:0] {STEP_LOAD, STEP_REQUEST, STEP_CONFIG} step_t;

  typedef struct packed {
    step_t              op;
    cfg_reg_t           sel;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic [RATIO_W-1:0] data;
    logic               typed;
    logic [PIX_W-1:0]   want;
  } dir_step_t;

  typedef struct packed {
    logic [COORD_W-1:0] row_o;
    logic [COORD_W-1:0] col_o;
    logic [CHAN_W-1:0]  p0;
    logic [CHAN_W-1:0]  p1;
    logic [CHAN_W-1:0]  p2;
  } pix_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RATIO_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 kind;
  logic [COORD_W-1:0]   row;
  logic [COORD_W-1:0]   col;
  logic [CHAN_W-1:0]    chan0;
  logic [CHAN_W-1:0]    chan1;
  logic [CHAN_W-1:0]    chan2;
  logic                 out_valid;
  logic                 out_stall;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic [CHAN_W-1:0]    pix0;
  logic [CHAN_W-1:0]    pix1;
  logic [CHAN_W-1:0]    pix2;

  logic [PIX_W-1:0]   shadow_frame [MAX_W*MAX_H];
  bit                 shadow_valid [MAX_W*MAX_H];
  logic [SIZE_W-1:0]  cfg_width;
  logic [SIZE_W-1:0]  cfg_height;
  logic [RATIO_W-1:0] cfg_x_ratio;
  logic [RATIO_W-1:0] cfg_y_ratio;
  pix_result_t        pending_pix [$];
  int                 mismatch_count = 0;
  int                 items_taken = 0;
  bit                 idle_en = 1'b1;
  bit                 hold_pending = 1'b0;

  dir_step_t directed_tbl [NUM_DIRECTED] = '{
    '{STEP_LOAD,    REG_SRC_WIDTH,  12'd0,    12'd0,    24'h332211, 1'b0, 24'h0},
    '{STEP_LOAD,    REG_SRC_WIDTH,  12'd0,    12'd1,    24'h8000FF, 1'b0, 24'h0},
    '{STEP_LOAD,    REG_SRC_WIDTH,  12'd1,    12'd0,    24'h01FF00, 1'b0, 24'h0},
    '{STEP_LOAD,    REG_SRC_WIDTH,  12'd1,    12'd1,    24'h007FFE, 1'b0, 24'h0},
    '{STEP_LOAD,    REG_SRC_WIDTH,  12'd512,  12'd0,    24'hAAAAAA, 1'b0, 24'h0},
    '{STEP_LOAD,    REG_SRC_WIDTH,  12'd0,    12'd512,  24'hBBBBBB, 1'b0, 24'h0},
    '{STEP_LOAD,    REG_SRC_WIDTH,  12'd4095, 12'd4095, 24'hCCCCCC, 1'b0, 24'h0},
    '{STEP_REQUEST, REG_SRC_WIDTH,  12'd0,    12'd0,    24'h0,      1'b1, 24'h332211},
    '{STEP_REQUEST, REG_SRC_WIDTH,  12'd1,    12'd0,    24'h0,      1'b1, 24'h01FF00},
    '{STEP_REQUEST, REG_SRC_WIDTH,  12'd0,    12'd1,    24'h0,      1'b1, 24'h8000FF},
    '{STEP_LOAD,    REG_SRC_WIDTH,  12'd511,  12'd511,  24'hFFFFFF, 1'b0, 24'h0},
    '{STEP_REQUEST, REG_SRC_WIDTH,  12'd511,  12'd511,  24'h0,      1'b1, 24'hFFFFFF},
    '{STEP_REQUEST, REG_SRC_WIDTH,  12'd4095, 12'd4095, 24'h0,      1'b1, 24'hFFFFFF},
    '{STEP_REQUEST, REG_SRC_WIDTH,  12'd4095, 12'd0,    24'h0,      1'b0, 24'h0},
    '{STEP_CONFIG,  REG_X_RATIO,    12'd0,    12'd0,    24'h008000, 1'b0, 24'h0},
    '{STEP_CONFIG,  REG_Y_RATIO,    12'd0,    12'd0,    24'h008000, 1'b0, 24'h0},
    '{STEP_REQUEST, REG_SRC_WIDTH,  12'd1,    12'd1,    24'h0,      1'b0, 24'h0},
    '{STEP_CONFIG,  REG_X_RATIO,    12'd0,    12'd0,    24'h000000, 1'b0, 24'h0},
    '{STEP_CONFIG,  REG_Y_RATIO,    12'd0,    12'd0,    24'h000000, 1'b0, 24'h0},
    '{STEP_REQUEST, REG_SRC_WIDTH,  12'd4095, 12'd4095, 24'h0,      1'b1, 24'h332211},
    '{STEP_CONFIG,  REG_X_RATIO,    12'd0,    12'd0,    24'hFFFFFF, 1'b0, 24'h0},
    '{STEP_CONFIG,  REG_Y_RATIO,    12'd0,    12'd0,    24'hFFFFFF, 1'b0, 24'h0},
    '{STEP_CONFIG,  REG_SRC_WIDTH,  12'd0,    12'd0,    24'h000000, 1'b0, 24'h0},
    '{STEP_CONFIG,  REG_SRC_HEIGHT, 12'd0,    12'd0,    24'hFFFFFF, 1'b0, 24'h0},
    '{STEP_REQUEST, REG_SRC_WIDTH,  12'd1,    12'd1,    24'h0,      1'b0, 24'h0}
  };

  bilinear_image_resize_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .row       (row),
    .col       (col),
    .chan0     (chan0),
    .chan1     (chan1),
    .chan2     (chan2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .pix0      (pix0),
    .pix1      (pix1),
    .pix2      (pix2)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      return 0;
    end else if (roll < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 25);
  endfunction

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] s, input int unsigned lim);
    if (s == '0) begin
      return 1;
    end else if (32'(s) > lim) begin
      return lim;
    end
    return 32'(s);
  endfunction

  function automatic void map_axis(input logic [COORD_W-1:0] coord,
                                   input logic [RATIO_W-1:0] ratio, input int unsigned last,
                                   output int unsigned i0, output int unsigned i1,
                                   output longint unsigned frac);
    longint unsigned pos;
    longint unsigned ip;
    pos = 64'(coord) * 64'(ratio);
    ip = pos >> FRAC;
    frac = pos & (ONE - 1);
    if (ip > 64'(last)) begin
      ip = 64'(last);
    end
    i0 = 32'(ip);
    i1 = (i0 < last) ? i0 + 1 : last;
  endfunction

  function automatic pix_result_t predict_pixel(input logic [COORD_W-1:0] r,
                                                input logic [COORD_W-1:0] c);
    int unsigned x0, x1, y0, y1;
    longint unsigned fx, fy, ifx, ify, acc;
    logic [PIX_W-1:0] pa, pb, pc, pd;
    logic [CHAN_W-1:0] chv [NUM_CHAN];
    pix_result_t res;
    int k;
    map_axis(c, cfg_x_ratio, eff_size(cfg_width, MAX_W) - 1, x0, x1, fx);
    map_axis(r, cfg_y_ratio, eff_size(cfg_height, MAX_H) - 1, y0, y1, fy);
    ifx = ONE - fx;
    ify = ONE - fy;
    pa = shadow_frame[y0*MAX_W + x0];
    pb = shadow_frame[y0*MAX_W + x1];
    pc = shadow_frame[y1*MAX_W + x0];
    pd = shadow_frame[y1*MAX_W + x1];
    for (k = 0; k < NUM_CHAN; k++) begin
      acc = 64'(pa[8*k +: 8]) * ifx * ify + 64'(pb[8*k +: 8]) * fx * ify
          + 64'(pc[8*k +: 8]) * ifx * fy + 64'(pd[8*k +: 8]) * fx * fy;
      acc = acc >> (2 * FRAC);
      if (acc > 255) begin
        acc = 255;
      end
      chv[k] = acc[7:0];
    end
    res.row_o = r;
    res.col_o = c;
    res.p0 = chv[0];
    res.p1 = chv[1];
    res.p2 = chv[2];
    return res;
  endfunction

  task automatic send_item(input logic k, input logic [COORD_W-1:0] r,
                           input logic [COORD_W-1:0] c, input logic [PIX_W-1:0] px,
                           input bit typed, input logic [PIX_W-1:0] want);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    row = r;
    col = c;
    chan0 = px[7:0];
    chan1 = px[15:8];
    chan2 = px[23:16];
    do @(posedge clk); while (in_stall);
    items_taken++;
    if (k == KIND_LOAD) begin
      if (32'(r) < MAX_H && 32'(c) < MAX_W) begin
        shadow_frame[32'(r) * MAX_W + 32'(c)] = px;
        shadow_valid[32'(r) * MAX_W + 32'(c)] = 1'b1;
      end
    end else begin
      if (typed) begin
        pending_pix.push_back('{r, c, want[7:0], want[15:8], want[23:16]});
      end else begin
        pending_pix.push_back(predict_pixel(r, c));
      end
    end
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Every store entry that a request will touch must be loaded before the request goes in.
  task automatic load_missing_neighbors(input logic [COORD_W-1:0] r,
                                        input logic [COORD_W-1:0] c);
    int unsigned x0, x1, y0, y1, yy, xx;
    longint unsigned fx, fy;
    int i;
    map_axis(c, cfg_x_ratio, eff_size(cfg_width, MAX_W) - 1, x0, x1, fx);
    map_axis(r, cfg_y_ratio, eff_size(cfg_height, MAX_H) - 1, y0, y1, fy);
    for (i = 0; i < 4; i++) begin
      yy = i[1] ? y1 : y0;
      xx = i[0] ? x1 : x0;
      if (!shadow_valid[yy*MAX_W + xx]) begin
        send_item(KIND_LOAD, COORD_W'(yy), COORD_W'(xx), PIX_W'($urandom), 1'b0, '0);
      end
    end
  endtask

  task automatic send_request(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                              input bit typed, input logic [PIX_W-1:0] want);
    load_missing_neighbors(r, c);
    send_item(KIND_REQUEST, r, c, PIX_W'($urandom), typed, want);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [RATIO_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SRC_WIDTH:  cfg_width = value[SIZE_W-1:0];
      REG_SRC_HEIGHT: cfg_height = value[SIZE_W-1:0];
      REG_X_RATIO:    cfg_x_ratio = value;
      REG_Y_RATIO:    cfg_y_ratio = value;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [RATIO_W-1:0] pick_size_data();
    logic [SIZE_W-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = SIZE_W'(1);
      2:       s = SIZE_W'(2);
      7:       s = SIZE_W'(512);
      8:       s = SIZE_W'($urandom_range(513, 1023));
      9:       s = SIZE_W'($urandom_range(13, 511));
      default: s = SIZE_W'($urandom_range(3, 12));
    endcase
    return (RATIO_W'($urandom) & 24'hFFFC00) | RATIO_W'(s);
  endfunction

  function automatic logic [RATIO_W-1:0] pick_ratio();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return 24'h010000;
      3:       return 24'h008000;
      7:       return RATIO_W'($urandom);
      8:       return 24'h000001;
      9:       return RATIO_W'($urandom_range(65536, 8 * 65536));
      default: return RATIO_W'($urandom_range(4096, 3 * 65536));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      4:       return COORD_W'($urandom_range(0, 4095));
      5:       return $urandom_range(0, 1) ? COORD_W'(4095) : COORD_W'(0);
      default: return COORD_W'($urandom_range(0, 23));
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned got, input int unsigned want,
                             input pix_result_t exp_pix);
    if (got != want) begin
      report_error($sformatf("%s of (%0d,%0d): got %0d, expected %0d",
                             name, exp_pix.row_o, exp_pix.col_o, got, want));
    end
  endtask

  always @(posedge clk) begin
    pix_result_t exp_pix;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pix.size() == 0) begin
        report_error($sformatf("result (%0d,%0d) with no request pending", out_row, out_col));
      end else begin
        exp_pix = pending_pix.pop_front();
        check_field("out_row", 32'(out_row), 32'(exp_pix.row_o), exp_pix);
        check_field("out_col", 32'(out_col), 32'(exp_pix.col_o), exp_pix);
        check_field("pix0", 32'(pix0), 32'(exp_pix.p0), exp_pix);
        check_field("pix1", 32'(pix1), 32'(exp_pix.p1), exp_pix);
        check_field("pix2", 32'(pix2), 32'(exp_pix.p2), exp_pix);
      end
    end
  end

  initial begin
    int run_len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        out_stall = 1'b1;
        for (run_len = 0; run_len < LONG_HOLD; run_len++) @(negedge clk);
        out_stall = 1'b0;
        hold_pending = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
  end

  initial begin
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int i;
    int phase;
    int phase_end;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned pr;
    int unsigned pc;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_SRC_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_LOAD;
    row = '0;
    col = '0;
    chan0 = '0;
    chan1 = '0;
    chan2 = '0;
    cfg_width = RST_SRC_WIDTH;
    cfg_height = RST_SRC_HEIGHT;
    cfg_x_ratio = RST_RATIO;
    cfg_y_ratio = RST_RATIO;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      case (directed_tbl[i].op)
        STEP_LOAD: begin
          send_item(KIND_LOAD, directed_tbl[i].r, directed_tbl[i].c, directed_tbl[i].data,
                    1'b0, '0);
        end
        STEP_REQUEST: begin
          send_request(directed_tbl[i].r, directed_tbl[i].c, directed_tbl[i].typed,
                       directed_tbl[i].want);
        end
        default: begin
          write_reg(directed_tbl[i].sel, directed_tbl[i].data);
        end
      endcase
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) begin
        write_reg(REG_SRC_WIDTH, 24'h000001);
        write_reg(REG_SRC_HEIGHT, 24'h5A07FF);
        write_reg(REG_X_RATIO, 24'h000001);
        write_reg(REG_Y_RATIO, 24'hFFFFFF);
      end else begin
        write_reg(REG_SRC_WIDTH, pick_size_data());
        write_reg(REG_SRC_HEIGHT, pick_size_data());
        write_reg(REG_X_RATIO, pick_ratio());
        write_reg(REG_Y_RATIO, pick_ratio());
      end
      idle_en = (phase != 1 && phase != 4);
      if (phase == 1) begin
        hold_pending = 1'b1;
      end
      w_eff = eff_size(cfg_width, MAX_W);
      h_eff = eff_size(cfg_height, MAX_H);
      // Small images are loaded whole in raster order, at random half the time, before they are sampled.
      if (w_eff * h_eff <= 48 && $urandom_range(0, 1) == 1) begin
        for (pr = 0; pr < h_eff; pr++) begin
          for (pc = 0; pc < w_eff; pc++) begin
            send_item(KIND_LOAD, COORD_W'(pr), COORD_W'(pc), PIX_W'($urandom), 1'b0, '0);
          end
        end
      end
      phase_end = items_taken + PHASE_ITEMS;
      while (items_taken < phase_end) begin
        case ($urandom_range(0, 9))
          6, 7: begin
            send_item(KIND_LOAD, COORD_W'($urandom_range(0, h_eff - 1)),
                      COORD_W'($urandom_range(0, w_eff - 1)), PIX_W'($urandom), 1'b0, '0);
          end
          8: begin
            send_item(KIND_LOAD, COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom),
                      1'b0, '0);
          end
          9: begin
            send_request(COORD_W'($urandom), COORD_W'($urandom), 1'b0, '0);
          end
          default: begin
            send_request(pick_coord(), pick_coord(), 1'b0, '0);
          end
        endcase
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    i = 0;
    while (pending_pix.size() != 0 && i < 20000) begin
      @(posedge clk);
      i++;
    end
    if (pending_pix.size() != 0) begin
      report_error($sformatf("%0d expected results never arrived", pending_pix.size()));
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
